// File: hw/rtl/gja_pkg.sv
// Shared types, constants and tables for the Gaussian jet actuation pipeline.
package gja_pkg;

    localparam int ATAN_ENTRIES = 24;

    // Pi in Q3.13 and four times atan(1) in Q.30
    localparam logic signed [18:0] PI_Q13    = 19'sd25736;
    localparam logic signed [35:0] ATAN0_X4  = 36'sd3373259424;
    localparam logic [16:0]        LOG2E_Q16 = 17'd94548;
    localparam logic [32:0]        E_LIMIT   = 33'd786432;

    typedef enum logic [1:0] {
        CFG_CENTER    = 2'd0,
        CFG_HALF      = 2'd1,
        CFG_INV_SIGMA = 2'd2
    } cfg_idx_t;

    // CORDIC vector state of one item
    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [35:0] z;
        logic               y_zero;
        logic               x_neg;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] g;
    } cordic_t;

    // Fields that ride along the weight and velocity stages
    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] g;
        logic               band;
        logic               pos;
    } carry_t;

    // Truncated atan(2^-i) in Q.30
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // Horner coefficients of 2^-r, highest order handled by the seed
    function automatic logic [16:0] horner_k(input logic [2:0] k);
        logic [16:0] v;
        case (k)
            3'd0: v = 17'd87;
            3'd1: v = 17'd630;
            3'd2: v = 17'd3638;
            3'd3: v = 17'd15743;
            3'd4: v = 17'd45426;
            3'd5: v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/gja_cordic_step.sv
// One registered CORDIC vectoring micro-rotation.
module gja_cordic_step #(
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vld_in,
    input  gja_pkg::cordic_t d_in,
    output logic             vld_out,
    output gja_pkg::cordic_t d_out
);

    logic             vld_reg;
    gja_pkg::cordic_t d_reg;
    gja_pkg::cordic_t d_next;
    logic signed [35:0] atan_s;

    assign atan_s = $signed({4'b0, gja_pkg::atan_q30(5'(STEP))});

    // Rotate toward the x axis, steer by the sign of y
    always_comb
    begin
        d_next = d_in;
        if (d_in.y > 0)
        begin
            d_next.x = d_in.x + (d_in.y >>> STEP);
            d_next.y = d_in.y - (d_in.x >>> STEP);
            d_next.z = d_in.z + atan_s;
        end
        else
        begin
            d_next.x = d_in.x - (d_in.y >>> STEP);
            d_next.y = d_in.y + (d_in.x >>> STEP);
            d_next.z = d_in.z - atan_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign vld_out = vld_reg;
    assign d_out   = d_reg;

endmodule

// File: hw/rtl/gja_gauss.sv
// Angle rounding, band test and Gaussian weighting of the gain.
module gja_gauss (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vld_in,
    input  gja_pkg::cordic_t   d_in,
    input  logic [14:0]        center,
    input  logic [14:0]        half,
    input  logic [15:0]        inv_sig,
    output logic               vld_out,
    output gja_pkg::carry_t    c_out,
    output logic signed [17:0] act_out
);

    localparam int HS = 6;

    // Stage 1: angle and magnitude
    logic               v1_reg;
    gja_pkg::carry_t    c1_reg;
    gja_pkg::carry_t    c1_next;
    logic [18:0]        mag1_reg;
    logic signed [35:0] zr;
    logic signed [18:0] ang;

    always_comb
    begin
        zr = (d_in.z + 36'sd65536) >>> 17;
        if (d_in.y_zero)
            ang = d_in.x_neg ? gja_pkg::PI_Q13 : 19'sd0;
        else
            ang = zr[18:0];
        c1_next.px   = d_in.px;
        c1_next.py   = d_in.py;
        c1_next.g    = d_in.g;
        c1_next.band = 1'b0;
        c1_next.pos  = (ang > 19'sd0);
    end

    always_ff @(posedge clk)
    begin
        c1_reg   <= c1_next;
        mag1_reg <= (ang < 19'sd0) ? 19'(-ang) : 19'(ang);
    end

    // Stage 2: band test and offset from center
    logic               v2_reg;
    gja_pkg::carry_t    c2_reg;
    gja_pkg::carry_t    c2_next;
    logic signed [17:0] d2_reg;
    logic signed [19:0] lo;
    logic signed [19:0] hi;
    logic signed [19:0] mag_s;

    assign lo    = $signed({5'b0, center}) - $signed({5'b0, half});
    assign hi    = $signed({5'b0, center}) + $signed({5'b0, half});
    assign mag_s = $signed({1'b0, mag1_reg});

    always_comb
    begin
        c2_next      = c1_reg;
        c2_next.band = !((mag_s < lo) || (mag_s > hi));
    end

    always_ff @(posedge clk)
    begin
        c2_reg <= c2_next;
        d2_reg <= 18'(mag_s - $signed({5'b0, center}));
    end

    // Stage 3: scale by inverse sigma
    logic               v3_reg;
    gja_pkg::carry_t    c3_reg;
    logic signed [22:0] t3_reg;
    logic signed [34:0] tprod;

    assign tprod = d2_reg * $signed({1'b0, inv_sig});

    always_ff @(posedge clk)
    begin
        c3_reg <= c2_reg;
        t3_reg <= 23'((tprod + 35'sd2048) >>> 12);
    end

    // Stage 4: half square
    logic               v4_reg;
    gja_pkg::carry_t    c4_reg;
    logic [19:0]        e4_reg;
    logic               z4_reg;
    logic [21:0]        tt;
    logic [43:0]        sq;
    logic [32:0]        e_full;

    assign tt     = (t3_reg < 0) ? 22'(-t3_reg) : 22'(t3_reg);
    assign sq     = tt * tt;
    assign e_full = 33'((sq + 44'd1024) >> 11);

    always_ff @(posedge clk)
    begin
        c4_reg <= c3_reg;
        e4_reg <= e_full[19:0];
        z4_reg <= (e_full >= gja_pkg::E_LIMIT);
    end

    // Stage 5: convert to base 2, split integer and fraction
    logic               v5_reg;
    gja_pkg::carry_t    c5_reg;
    logic [4:0]         n5_reg;
    logic [15:0]        r5_reg;
    logic               z5_reg;
    logic [36:0]        fprod;
    logic [20:0]        f;

    assign fprod = e4_reg * gja_pkg::LOG2E_Q16;
    assign f     = 21'((fprod + 37'd32768) >> 16);

    always_ff @(posedge clk)
    begin
        c5_reg <= c4_reg;
        n5_reg <= f[20:16];
        r5_reg <= f[15:0];
        z5_reg <= z4_reg;
    end

    // Stages 6..11: Horner evaluation of 2^-r, one term per stage
    logic            hv_reg [HS];
    gja_pkg::carry_t hc_reg [HS];
    logic [4:0]      hn_reg [HS];
    logic [15:0]     hr_reg [HS];
    logic            hz_reg [HS];
    logic [16:0]     hp_reg [HS];

    for (genvar k = 0; k < HS; k++)
    begin : g_horner
        logic [16:0] p_in;
        logic [15:0] r_in;
        logic [32:0] pr;

        assign p_in = (k == 0) ? 17'd10 : hp_reg[(k == 0) ? 0 : k - 1];
        assign r_in = (k == 0) ? r5_reg : hr_reg[(k == 0) ? 0 : k - 1];
        assign pr   = p_in * r_in;

        always_ff @(posedge clk)
        begin
            if (k == 0)
            begin
                hc_reg[k] <= c5_reg;
                hn_reg[k] <= n5_reg;
                hz_reg[k] <= z5_reg;
            end
            else
            begin
                hc_reg[k] <= hc_reg[(k == 0) ? 0 : k - 1];
                hn_reg[k] <= hn_reg[(k == 0) ? 0 : k - 1];
                hz_reg[k] <= hz_reg[(k == 0) ? 0 : k - 1];
            end
            hr_reg[k] <= r_in;
            hp_reg[k] <= gja_pkg::horner_k(3'(k)) - pr[32:16];
        end
    end

    // Stage 12: shift by integer part, apply to gain
    logic               v12_reg;
    gja_pkg::carry_t    c12_reg;
    logic signed [17:0] act12_reg;
    logic [16:0]        w;
    logic signed [33:0] aprod;

    assign w     = hz_reg[HS-1] ? 17'd0 : (hp_reg[HS-1] >> hn_reg[HS-1]);
    assign aprod = $signed({1'b0, w}) * hc_reg[HS-1].g;

    always_ff @(posedge clk)
    begin
        c12_reg   <= hc_reg[HS-1];
        act12_reg <= 18'((aprod + 34'sd32768) >>> 16);
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v12_reg <= 1'b0;
            for (int i = 0; i < HS; i++)
                hv_reg[i] <= 1'b0;
        end
        else
        begin
            v1_reg    <= vld_in;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            hv_reg[0] <= v5_reg;
            for (int i = 1; i < HS; i++)
                hv_reg[i] <= hv_reg[i-1];
            v12_reg   <= hv_reg[HS-1];
        end
    end

    assign vld_out = v12_reg;
    assign c_out   = c12_reg;
    assign act_out = act12_reg;

`ifndef NO_ASSERTIONS
    // A weight cut to zero leaves no activation
    a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (hv_reg[HS-1] && hz_reg[HS-1]) |=> (act12_reg == 18'sd0))
        else $error("zero weight gave nonzero activation");
`endif

endmodule

// File: hw/rtl/gja_vel.sv
// Tangential velocity products with rounding and saturation.
module gja_vel (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vld_in,
    input  gja_pkg::carry_t    c_in,
    input  logic signed [17:0] act,
    output logic               done,
    output logic signed [15:0] u_vel,
    output logic signed [15:0] v_vel,
    output logic               in_band
);

    logic               va_reg;
    logic               band_a_reg;
    logic signed [34:0] pu_reg;
    logic signed [34:0] pv_reg;
    logic signed [16:0] su;
    logic signed [16:0] sv;

    // Pick signs so that the flow runs along the angle's direction
    always_comb
    begin
        if (c_in.pos)
        begin
            su = 17'(c_in.py);
            sv = -17'(c_in.px);
        end
        else
        begin
            su = -17'(c_in.py);
            sv = 17'(c_in.px);
        end
    end

    always_ff @(posedge clk)
    begin
        pu_reg     <= su * act;
        pv_reg     <= sv * act;
        band_a_reg <= c_in.band;
    end

    // Round to Q4.12 and clamp to 16 bits
    function automatic logic signed [15:0] sat_q12(input logic signed [34:0] p);
        logic signed [22:0] v;
        logic signed [15:0] r;
        v = 23'((p + 35'sd2048) >>> 12);
        if (v > 23'sd32767)
            r = 16'sh7FFF;
        else if (v < -23'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    logic               done_reg;
    logic               band_reg;
    logic signed [15:0] u_reg;
    logic signed [15:0] v_reg;

    always_ff @(posedge clk)
    begin
        u_reg <= band_a_reg ? sat_q12(pu_reg) : 16'sd0;
        v_reg <= band_a_reg ? sat_q12(pv_reg) : 16'sd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            done_reg <= 1'b0;
            band_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= vld_in;
            done_reg <= va_reg;
            band_reg <= va_reg && band_a_reg;
        end
    end

    assign done    = done_reg;
    assign in_band = band_reg;
    assign u_vel   = u_reg;
    assign v_vel   = v_reg;

endmodule

// File: hw/rtl/gaussian_jet_actuation.sv
// Top level of the Gaussian jet actuation pipeline.
//
// Usage: drive x_pos, y_pos and gain with start high for one cycle per item;
// busy stays low, so an item may be issued in every cycle. Each item yields
// one result: u_vel, v_vel and in_band are shown for one cycle with done
// high, and must be taken then; the receiver cannot hold results back.
// The path holds one input register, one stage per CORDIC micro-rotation
// (CORDIC_STEPS, capped at 24), twelve weight stages (angle, band test,
// scale, square, base-2 split, six Horner terms, gain product) and two
// velocity stages. Throughput is one item per cycle.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 center
// angle, 1 half width, 2 inverse sigma); other indexes are ignored. Write
// only while no item is in flight.
// Reset clears all valid bits and loads the default band and sigma; items
// in flight are dropped.
module gaussian_jet_actuation #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] x_pos,
    input  logic signed [15:0] y_pos,
    input  logic signed [15:0] gain,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    output logic               done,
    output logic signed [15:0] u_vel,
    output logic signed [15:0] v_vel,
    output logic               in_band
);

    localparam int NS = (CORDIC_STEPS > gja_pkg::ATAN_ENTRIES) ?
                        gja_pkg::ATAN_ENTRIES : CORDIC_STEPS;

    // Configuration registers
    logic [14:0] center_reg;
    logic [14:0] half_reg;
    logic [15:0] inv_sig_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg  <= 15'd12868;
            half_reg    <= 15'd4289;
            inv_sig_reg <= 16'd4096;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                gja_pkg::CFG_CENTER:    center_reg  <= cfg_wdata[14:0];
                gja_pkg::CFG_HALF:      half_reg    <= cfg_wdata[14:0];
                gja_pkg::CFG_INV_SIGMA: inv_sig_reg <= cfg_wdata;
                default:                ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Input stage: scale and fold the left half plane
    logic             v0_reg;
    gja_pkg::cordic_t d0_reg;
    gja_pkg::cordic_t d0_next;
    logic signed [32:0] xs;
    logic signed [32:0] ys;

    always_comb
    begin
        xs = 33'(x_pos) <<< 14;
        ys = 33'(y_pos) <<< 14;
        d0_next.px     = x_pos;
        d0_next.py     = y_pos;
        d0_next.g      = gain;
        d0_next.y_zero = (y_pos == 16'sd0);
        d0_next.x_neg  = (x_pos < 16'sd0);
        if (x_pos < 16'sd0)
        begin
            d0_next.x = -xs;
            d0_next.y = -ys;
            d0_next.z = (y_pos > 16'sd0) ? gja_pkg::ATAN0_X4 : -gja_pkg::ATAN0_X4;
        end
        else
        begin
            d0_next.x = xs;
            d0_next.y = ys;
            d0_next.z = 36'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        d0_reg <= d0_next;
    end

    // CORDIC chain, one micro-rotation per stage
    logic             cv [NS+1];
    gja_pkg::cordic_t cd [NS+1];

    assign cv[0] = v0_reg;
    assign cd[0] = d0_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_cordic
        gja_cordic_step #(
            .STEP (i)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .vld_in  (cv[i]),
            .d_in    (cd[i]),
            .vld_out (cv[i+1]),
            .d_out   (cd[i+1])
        );
    end

    // Weighting
    logic               gv;
    gja_pkg::carry_t    gc;
    logic signed [17:0] gact;

    gja_gauss u_gauss (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (cv[NS]),
        .d_in    (cd[NS]),
        .center  (center_reg),
        .half    (half_reg),
        .inv_sig (inv_sig_reg),
        .vld_out (gv),
        .c_out   (gc),
        .act_out (gact)
    );

    // Velocity output
    gja_vel u_vel_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (gv),
        .c_in    (gc),
        .act     (gact),
        .done    (done),
        .u_vel   (u_vel),
        .v_vel   (v_vel),
        .in_band (in_band)
    );

`ifndef NO_ASSERTIONS
    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_band) |-> (u_vel == 16'sd0 && v_vel == 16'sd0))
        else $error("out of band result with nonzero velocity");

    a_band_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> !in_band)
        else $error("in_band raised without a result");
`endif

endmodule
